/* rtl/awac_pkg.sv */
`default_nettype none

package awac_pkg;

   localparam int FUNC_W      = 2;
   localparam int CHAN_W      = 5;
   localparam int SAMPLE_W    = 12;
   localparam int DATA_W      = 32;
   localparam int VOLT_W      = 16;
   localparam int FRAC_SHIFT  = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int VOLT_MAX    = 32767;
   localparam int VOLT_MIN_MAG = 32768;

   localparam logic [FUNC_W-1:0] FUNC_PUSH      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RESTART   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CALIBRATE = 2'd3;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_RESTART,
      OP_READ,
      OP_READ_NULL,
      OP_CALIBRATE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
      logic [DATA_W-1:0]   gain_value;
      logic [DATA_W-1:0]   offset_value;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/awac_req_if.sv */
`default_nettype none

interface awac_req_if;
   logic                                valid;
   logic                                ready;
   logic        [awac_pkg::FUNC_W-1:0]   func;
   logic        [awac_pkg::CHAN_W-1:0]   channel;
   logic        [awac_pkg::SAMPLE_W-1:0] sample;
   logic signed [awac_pkg::DATA_W-1:0]   gain_value;
   logic signed [awac_pkg::DATA_W-1:0]   offset_value;

   modport source (
      output valid, func, channel, sample, gain_value, offset_value,
      input  ready
   );

   modport sink (
      input  valid, func, channel, sample, gain_value, offset_value,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/awac_rsp_if.sv */
`default_nettype none

interface awac_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [awac_pkg::VOLT_W-1:0] voltage;
   logic                              valid_res;

   modport source (
      output valid, voltage, valid_res,
      input  ready
   );

   modport sink (
      input  valid, voltage, valid_res,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/awac_ram.sv */
`default_nettype none

module awac_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/awac_front.sv */
`default_nettype none

module awac_front #(
   parameter int CHANNELS    = 32,
   parameter int SAMPLE_BITS = 12
) (
   awac_req_if.sink           req_chan,
   input  wire logic          q_ready,
   output      logic          q_push,
   output awac_pkg::cmd_type  q_cmd
);

   localparam int KEEP_BITS = (SAMPLE_BITS < awac_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                 : awac_pkg::SAMPLE_W;
   localparam logic [awac_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
      awac_pkg::SAMPLE_W'((1 << KEEP_BITS) - 1);

   logic in_range;
   logic keep;

   assign in_range = 32'(req_chan.channel) < CHANNELS;

   always_comb begin
      q_cmd.channel      = req_chan.channel;
      q_cmd.sample       = req_chan.sample & SAMPLE_MASK;
      q_cmd.gain_value   = req_chan.gain_value;
      q_cmd.offset_value = req_chan.offset_value;
      keep               = in_range;
      unique case (req_chan.func)
         awac_pkg::FUNC_PUSH:    q_cmd.op = awac_pkg::OP_PUSH;
         awac_pkg::FUNC_RESTART: q_cmd.op = awac_pkg::OP_RESTART;
         awac_pkg::FUNC_READ: begin
            q_cmd.op = in_range ? awac_pkg::OP_READ : awac_pkg::OP_READ_NULL;
            keep     = 1'b1;
         end
         default:                q_cmd.op = awac_pkg::OP_CALIBRATE;
      endcase
   end

   // drop out-of-range writes, keep every read
   assign req_chan.ready = q_ready;
   assign q_push         = req_chan.valid && q_ready && keep;

endmodule

`default_nettype wire

/* rtl/awac_queue.sv */
`default_nettype none

module awac_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output      logic              push_ready,
   input  wire awac_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output      logic              pop_valid,
   output awac_pkg::cmd_type      pop_cmd
);

   localparam int DEPTH = awac_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   awac_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push;
   logic              do_pop;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_cmd;
            wr_ptr_ff           <= advance(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= advance(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/awac_back.sv */
`default_nettype none

module awac_back #(
   parameter int CHANNELS    = 32,
   parameter int WINDOW      = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire awac_pkg::cmd_type q_cmd,
   output      logic              q_pop,
   awac_rsp_if.source             rsp_chan
);

   localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W     = $clog2(WINDOW);
   localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
   localparam int SUM_SHIFT = $clog2(WINDOW + 1) - 2;
   localparam int SMP_DEPTH = CHANNELS * WINDOW;
   localparam int SA_W      = $clog2(SMP_DEPTH);
   localparam int DW        = awac_pkg::DATA_W;
   localparam int VW        = awac_pkg::VOLT_W;
   localparam int MAG_W     = DW - awac_pkg::FRAC_SHIFT;

   typedef struct packed {
      logic                   full;
      logic [POS_W-1:0]       pos;
      logic [SAMPLE_BITS-1:0] fill;
      logic [SUM_W-1:0]       sum;
   } chan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MERGE,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [CHANNELS-1:0] started_ff;
   awac_pkg::cmd_type cmd_ff;
   logic              null_ff;
   logic [DW-1:0]     product_ff;
   logic [DW-1:0]     offset_ff;
   logic [DW-1:0]     acc_ff;
   logic              rsp_valid_ff;
   logic [VW-1:0]     voltage_ff;
   logic              valid_res_ff;

   logic [CH_AW-1:0]       head_ch;
   logic [CH_AW-1:0]       cmd_ch;
   logic                   head_started;
   logic [SAMPLE_BITS-1:0] head_sample;
   logic [SAMPLE_BITS-1:0] cmd_sample;
   logic                   idle_take;
   logic                   first_push;
   logic                   merging;

   chan_type               rec;
   chan_type               first_rec;
   chan_type               merge_rec;
   logic [$bits(chan_type)-1:0] chan_rd;
   logic                   chan_wr_en;
   logic [CH_AW-1:0]       chan_wr_addr;
   logic [$bits(chan_type)-1:0] chan_wr_data;

   logic [2*DW-1:0]        cal_rd;
   logic                   cal_wr_en;

   logic [SAMPLE_BITS-1:0] smp_rd;
   logic                   smp_wr_en;
   logic [SA_W-1:0]        smp_wr_addr;
   logic [SAMPLE_BITS-1:0] smp_wr_data;
   logic                   smp_rd_en;
   logic [SA_W-1:0]        smp_rd_addr;

   logic [POS_W:0]         pos_inc;
   logic                   pos_wrap;
   logic [SAMPLE_BITS-1:0] old_sample;
   logic [DW-1:0]          product_in;

   logic                   acc_neg;
   logic [DW-1:0]          acc_mag;
   logic [MAG_W-1:0]       mag_sh;
   logic [MAG_W-1:0]       mag_neg;
   logic [VW-1:0]          volt_in;
   logic                   out_free;

   function automatic logic [SA_W-1:0] smp_addr(input logic [CH_AW-1:0] ch,
                                                input logic [POS_W-1:0] pos);
      return SA_W'(ch) * SA_W'(WINDOW) + SA_W'(pos);
   endfunction

   assign head_ch      = CH_AW'(q_cmd.channel);
   assign cmd_ch       = CH_AW'(cmd_ff.channel);
   assign head_started = started_ff[head_ch];
   assign head_sample  = SAMPLE_BITS'(q_cmd.sample);
   assign cmd_sample   = SAMPLE_BITS'(cmd_ff.sample);
   assign idle_take    = (state_ff == ST_IDLE) && q_valid;
   assign q_pop        = idle_take;
   assign first_push   = idle_take && (q_cmd.op == awac_pkg::OP_PUSH) && !head_started;
   assign merging      = state_ff == ST_MERGE;

   assign rec = chan_type'(chan_rd);

   // first push after restart: the whole window holds this sample
   always_comb begin
      first_rec.full = 1'b0;
      first_rec.pos  = POS_W'(1);
      first_rec.fill = head_sample;
      first_rec.sum  = SUM_W'(SUM_W'(head_sample) * SUM_W'(WINDOW));
   end

   assign pos_inc    = (POS_W + 1)'(rec.pos) + 1'b1;
   assign pos_wrap   = pos_inc >= (POS_W + 1)'(WINDOW);
   assign old_sample = rec.full ? smp_rd : rec.fill;

   always_comb begin
      merge_rec.full = rec.full | pos_wrap;
      merge_rec.pos  = pos_wrap ? '0 : pos_inc[POS_W-1:0];
      merge_rec.fill = rec.fill;
      merge_rec.sum  = rec.sum - SUM_W'(old_sample) + SUM_W'(cmd_sample);
   end

   assign chan_wr_en   = first_push || merging;
   assign chan_wr_addr = merging ? cmd_ch : head_ch;
   assign chan_wr_data = merging ? merge_rec : first_rec;

   assign smp_wr_en   = first_push || merging;
   assign smp_wr_addr = merging ? smp_addr(cmd_ch, rec.pos) : smp_addr(head_ch, '0);
   assign smp_wr_data = merging ? cmd_sample : head_sample;
   assign smp_rd_en   = state_ff == ST_LOAD;
   assign smp_rd_addr = smp_addr(cmd_ch, rec.pos);

   assign cal_wr_en = idle_take && (q_cmd.op == awac_pkg::OP_CALIBRATE);

   assign product_in = cal_rd[2*DW-1:DW] * DW'(rec.sum >> SUM_SHIFT);

   assign acc_neg = acc_ff[DW-1] || (acc_ff == '0);
   assign acc_mag = acc_neg ? (~acc_ff + 1'b1) : acc_ff;
   assign mag_sh  = acc_mag[DW-1:awac_pkg::FRAC_SHIFT];
   assign mag_neg = ~mag_sh + 1'b1;

   always_comb begin
      if (null_ff) begin
         volt_in = '0;
      end else if (acc_neg) begin
         volt_in = (mag_sh > MAG_W'(awac_pkg::VOLT_MIN_MAG)) ? VW'(awac_pkg::VOLT_MIN_MAG)
                                                          : mag_neg[VW-1:0];
      end else begin
         volt_in = (mag_sh > MAG_W'(awac_pkg::VOLT_MAX)) ? VW'(awac_pkg::VOLT_MAX)
                                                       : mag_sh[VW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   awac_ram #(
      .WIDTH ($bits(chan_type)),
      .DEPTH (CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (chan_wr_en),
      .wr_addr (chan_wr_addr),
      .wr_data (chan_wr_data),
      .rd_en   (idle_take),
      .rd_addr (head_ch),
      .rd_data (chan_rd)
   );

   awac_ram #(
      .WIDTH (2 * DW),
      .DEPTH (CHANNELS)
   ) u_cal_ram (
      .clock   (clock),
      .wr_en   (cal_wr_en),
      .wr_addr (head_ch),
      .wr_data ({q_cmd.gain_value, q_cmd.offset_value}),
      .rd_en   (idle_take),
      .rd_addr (head_ch),
      .rd_data (cal_rd)
   );

   awac_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (SMP_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (smp_wr_en),
      .wr_addr (smp_wr_addr),
      .wr_data (smp_wr_data),
      .rd_en   (smp_rd_en),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_cmd;
                  unique case (q_cmd.op)
                     awac_pkg::OP_PUSH: begin
                        if (head_started) begin
                           state_ff <= ST_LOAD;
                        end else begin
                           started_ff[head_ch] <= 1'b1;
                        end
                     end
                     awac_pkg::OP_RESTART: begin
                        started_ff[head_ch] <= 1'b0;
                     end
                     awac_pkg::OP_READ: begin
                        null_ff  <= !head_started;
                        state_ff <= head_started ? ST_LOAD : ST_EMIT;
                     end
                     awac_pkg::OP_READ_NULL: begin
                        null_ff  <= 1'b1;
                        state_ff <= ST_EMIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_LOAD: begin
               if (cmd_ff.op == awac_pkg::OP_PUSH) begin
                  state_ff <= ST_MERGE;
               end else begin
                  product_ff <= product_in;
                  offset_ff  <= cal_rd[DW-1:0];
                  state_ff   <= ST_ADD;
               end
            end
            ST_MERGE: begin
               state_ff <= ST_IDLE;
            end
            ST_ADD: begin
               acc_ff   <= product_ff + offset_ff;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               // hold the result register until it is free
               rsp_valid_ff <= !out_free || 1'b1;
               if (out_free) begin
                  voltage_ff   <= volt_in;
                  valid_res_ff <= !null_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.voltage   = voltage_ff;
   assign rsp_chan.valid_res = valid_res_ff;

endmodule

`default_nettype wire

/* rtl/adc_window_average_calibrate_core.sv */
// Multi-channel ADC window averager with per-channel gain and offset. Push
// (func 0) writes a sample into the channel's ring window; the first push after
// restart fills the whole window. Restart (func 1) marks the channel unstarted.
// Read (func 2) returns (gain * (window sum >> (log2(WINDOW)-1)) + offset) / 4096,
// saturated to 16 bits, with valid_res low for a channel not started.
// Calibrate (func 3) writes gain and offset. Transactions pass a two-entry
// queue into the execution unit, which handles one at a time: restart,
// calibrate and the first push after restart finish in the idle state; other
// pushes read channel state, then read sample memory, then write; reads load,
// multiply, add, then wait for a free result register (a channel not started
// goes straight to that wait). Each channel keeps a running sum, so a read
// never sweeps the window. No clearing pass after reset.
`default_nettype none

module adc_window_average_calibrate_core #(
   parameter int CHANNELS    = 32,
   parameter int WINDOW      = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic  clock,
   input  wire logic  reset,
   awac_req_if.sink   req_chan,
   awac_rsp_if.source rsp_chan
);

   logic              q_push;
   logic              q_ready;
   awac_pkg::cmd_type push_cmd;
   logic              q_valid;
   logic              q_pop;
   awac_pkg::cmd_type head_cmd;

   awac_front #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .req_chan (req_chan),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   awac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_ready (q_ready),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (head_cmd)
   );

   awac_back #(
      .CHANNELS    (CHANNELS),
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (head_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

/* test/adc_window_average_calibrate_core_tb.sv */
`timescale 1ns / 100ps

module adc_window_average_calibrate_core_tb;

   localparam int CHANNELS     = 32;
   localparam int WINDOW       = 16;
   localparam int SUM_SHIFT    = $clog2(WINDOW) - 1;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CW           = awac_pkg::CHAN_W;
   localparam int DW           = awac_pkg::DATA_W;
   localparam int SW           = awac_pkg::SAMPLE_W;
   localparam int VW           = awac_pkg::VOLT_W;

   typedef struct {
      logic signed [VW-1:0] voltage;
      logic                 valid_res;
   } reading_type;

   class channel_average_scoreboard;
      logic [SW-1:0] window_samples [CHANNELS][WINDOW];
      int unsigned   write_slot [CHANNELS];
      bit            started [CHANNELS];
      logic [DW-1:0] gain [CHANNELS];
      logic [DW-1:0] offset [CHANNELS];
      reading_type   expected_readings [$];
      int            mismatches;
      int            readings_checked;
      int            func_count [4];

      function reading_type calibrated_voltage(int ch);
         logic [DW-1:0] window_sum;
         logic [DW-1:0] acc;
         logic [DW-1:0] mag;
         bit            negative;
         reading_type   r;
         window_sum = '0;
         for (int i = 0; i < WINDOW; i++) window_sum += DW'(window_samples[ch][i]);
         window_sum = window_sum >> SUM_SHIFT;
         acc = gain[ch] * window_sum + offset[ch];
         negative = acc[DW-1] || (acc == '0);
         mag = (negative ? -acc : acc) >> awac_pkg::FRAC_SHIFT;
         if (negative) begin
            if (mag > DW'(awac_pkg::VOLT_MIN_MAG)) mag = DW'(awac_pkg::VOLT_MIN_MAG);
            mag = -mag;
         end else if (mag > DW'(awac_pkg::VOLT_MAX)) begin
            mag = DW'(awac_pkg::VOLT_MAX);
         end
         r.voltage   = mag[VW-1:0];
         r.valid_res = 1'b1;
         return r;
      endfunction

      function void note_request(logic [awac_pkg::FUNC_W-1:0] func, logic [CW-1:0] ch,
                                 logic [SW-1:0] smp, logic [DW-1:0] g,
                                 logic [DW-1:0] o);
         reading_type r;
         func_count[func]++;
         case (func)
            awac_pkg::FUNC_PUSH: begin
               if (!started[ch]) begin
                  started[ch]    = 1'b1;
                  write_slot[ch] = 0;
                  for (int i = 0; i < WINDOW; i++) window_samples[ch][i] = smp;
               end else begin
                  window_samples[ch][write_slot[ch]] = smp;
               end
               write_slot[ch] = (write_slot[ch] + 1) % WINDOW;
            end
            awac_pkg::FUNC_RESTART: started[ch] = 1'b0;
            awac_pkg::FUNC_READ: begin
               if (started[ch]) begin
                  r = calibrated_voltage(ch);
               end else begin
                  r.voltage   = '0;
                  r.valid_res = 1'b0;
               end
               expected_readings.push_back(r);
            end
            awac_pkg::FUNC_CALIBRATE: begin
               gain[ch]   = g;
               offset[ch] = o;
            end
         endcase
      endfunction

      function void check_response(logic signed [VW-1:0] voltage, logic valid_res);
         reading_type want;
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual voltage %0d valid_res %0b",
                     $time, voltage, valid_res);
            mismatches++;
            return;
         end
         want = expected_readings.pop_front();
         readings_checked++;
         if (voltage !== want.voltage) begin
            $display("%0t: voltage mismatch, expected %0d, actual %0d",
                     $time, want.voltage, voltage);
            mismatches++;
         end
         if (valid_res !== want.valid_res) begin
            $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                     $time, want.valid_res, valid_res);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   int   stall_left;

   channel_average_scoreboard sb = new;

   awac_req_if req_chan ();
   awac_rsp_if rsp_chan ();

   adc_window_average_calibrate_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[adc_window_average_calibrate_core] ERROR");
      $finish;
   end

   function automatic int idle_cycles();
      int pick;
      if (quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DW-1:0] random_coefficient(int half_span, int nominal);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 2 * half_span)) - half_span;
         6: return nominal;
         7, 8: return $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   task automatic send_request(input logic [awac_pkg::FUNC_W-1:0] func,
                               input logic [CW-1:0] ch,
                               input logic [SW-1:0] smp = '0,
                               input logic [DW-1:0] g = '0,
                               input logic [DW-1:0] o = '0);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= func;
      req_chan.channel      <= ch;
      req_chan.sample       <= smp;
      req_chan.gain_value   <= g;
      req_chan.offset_value <= o;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(func, ch, smp, g, o);
   endtask

   // response side: random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_response(rsp_chan.voltage, rsp_chan.valid_res);
      end
   end

   initial begin
      logic [CW-1:0] ch;
      int            pick;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.func         <= awac_pkg::FUNC_PUSH;
      req_chan.channel      <= '0;
      req_chan.sample       <= '0;
      req_chan.gain_value   <= '0;
      req_chan.offset_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // unstarted channels
      send_request(awac_pkg::FUNC_READ, CW'(0));
      send_request(awac_pkg::FUNC_READ, CW'(CHANNELS - 1));
      // zero result
      send_request(awac_pkg::FUNC_CALIBRATE, CW'(0), '0, '0, '0);
      send_request(awac_pkg::FUNC_PUSH, CW'(0), '0);
      send_request(awac_pkg::FUNC_READ, CW'(0));
      // unity gain, full scale, then ring overwrite
      send_request(awac_pkg::FUNC_CALIBRATE, CW'(1), '0, 32'd4096, '0);
      send_request(awac_pkg::FUNC_PUSH, CW'(1), 12'hFFF);
      send_request(awac_pkg::FUNC_READ, CW'(1));
      send_request(awac_pkg::FUNC_PUSH, CW'(1), '0);
      send_request(awac_pkg::FUNC_READ, CW'(1));
      // positive and negative saturation
      send_request(awac_pkg::FUNC_CALIBRATE, CW'(2), '0, 32'd32768, '0);
      send_request(awac_pkg::FUNC_PUSH, CW'(2), 12'hFFF);
      send_request(awac_pkg::FUNC_READ, CW'(2));
      send_request(awac_pkg::FUNC_CALIBRATE, CW'(3), '0, -32'sd32768, '0);
      send_request(awac_pkg::FUNC_PUSH, CW'(3), 12'hFFF);
      send_request(awac_pkg::FUNC_READ, CW'(3));
      // extreme coefficients, product wraps
      send_request(awac_pkg::FUNC_CALIBRATE, CW'(CHANNELS - 1), '0, 32'h8000_0000,
                   32'h7FFF_FFFF);
      send_request(awac_pkg::FUNC_PUSH, CW'(CHANNELS - 1), 12'hFFF);
      send_request(awac_pkg::FUNC_READ, CW'(CHANNELS - 1));
      // restart, then refill on next push
      send_request(awac_pkg::FUNC_RESTART, CW'(1));
      send_request(awac_pkg::FUNC_READ, CW'(1));
      send_request(awac_pkg::FUNC_PUSH, CW'(1), 12'd100);
      send_request(awac_pkg::FUNC_READ, CW'(1));

      for (int c = 0; c < CHANNELS; c++) begin
         send_request(awac_pkg::FUNC_CALIBRATE, CW'(c), 12'($urandom),
                      random_coefficient(16384, 4096), random_coefficient(1 << 23, 0));
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = ((n / 200) % 4) == 3;
         ch    = $urandom_range(0, 1) ? CW'($urandom_range(0, 3))
                                      : CW'($urandom_range(0, CHANNELS - 1));
         pick  = $urandom_range(0, 99);
         if (pick < 55) begin
            send_request(awac_pkg::FUNC_PUSH, ch, 12'($urandom), $urandom, $urandom);
         end else if (pick < 85) begin
            send_request(awac_pkg::FUNC_READ, ch, 12'($urandom), $urandom, $urandom);
         end else if (pick < 90) begin
            send_request(awac_pkg::FUNC_RESTART, ch, 12'($urandom), $urandom, $urandom);
         end else begin
            send_request(awac_pkg::FUNC_CALIBRATE, ch, 12'($urandom),
                         random_coefficient(16384, 4096), random_coefficient(1 << 23, 0));
         end
      end
      quiet = 1'b0;
      req_chan.valid <= 1'b0;

      while (sb.expected_readings.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d pushes, %0d restarts, %0d reads, %0d calibration writes",
               sb.func_count[awac_pkg::FUNC_PUSH], sb.func_count[awac_pkg::FUNC_RESTART],
               sb.func_count[awac_pkg::FUNC_READ], sb.func_count[awac_pkg::FUNC_CALIBRATE]);
      $display("Checked %0d read responses, %0d mismatches", sb.readings_checked,
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("[adc_window_average_calibrate_core] OK");
      end else begin
         $display("[adc_window_average_calibrate_core] ERROR");
      end
      $finish;
   end

endmodule
